// ===== rtl/oiwf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oiwf_pkg
// Shared types and constants for the display controller I2C write framer.
// ----------------------------------------------------------------------------
package oiwf_pkg;

	localparam int SYM_KIND_W = 2;
	localparam logic [SYM_KIND_W-1:0] SYM_START = 2'd0;
	localparam logic [SYM_KIND_W-1:0] SYM_BIT   = 2'd1;
	localparam logic [SYM_KIND_W-1:0] SYM_ACK   = 2'd2;
	localparam logic [SYM_KIND_W-1:0] SYM_STOP  = 2'd3;

	localparam logic [7:0] SLAVE_ADDR_RESET = 8'h78;
	localparam logic [7:0] CTRL_COMMAND     = 8'h00;
	localparam logic [7:0] CTRL_DATA        = 8'h40;

	localparam int FRAME_SYMBOLS = 29;
	localparam int POS_W = $clog2(FRAME_SYMBOLS);
	localparam logic [POS_W-1:0] POS_START = POS_W'(0);
	localparam logic [POS_W-1:0] POS_ACK0  = POS_W'(9);
	localparam logic [POS_W-1:0] POS_ACK1  = POS_W'(18);
	localparam logic [POS_W-1:0] POS_ACK2  = POS_W'(27);
	localparam logic [POS_W-1:0] POS_STOP  = POS_W'(FRAME_SYMBOLS - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] ctrl;
		logic [7:0] payload;
	} frame_t;

endpackage : oiwf_pkg
`default_nettype wire

// ===== rtl/oiwf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oiwf_item_if / oiwf_symbol_if
// Valid/ready channels for input bytes and for the bus symbols sent out.
// ----------------------------------------------------------------------------
interface oiwf_item_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] payload;

	modport source (output valid, output func, output payload, input ready);
	modport sink (input valid, input func, input payload, output ready);
endinterface : oiwf_item_if

interface oiwf_symbol_if;
	logic       valid;
	logic       ready;
	logic [1:0] symbol_kind;
	logic       sda_level;
	logic       last_symbol;

	modport source (output valid, output symbol_kind, output sda_level,
		output last_symbol, input ready);
	modport sink (input valid, input symbol_kind, input sda_level,
		input last_symbol, output ready);
endinterface : oiwf_symbol_if
`default_nettype wire

// ===== rtl/oiwf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oiwf_front
// Accepts input items and registers them as frame descriptors.
// ----------------------------------------------------------------------------
module oiwf_front (
	input  wire              clk,
	input  wire              arst_n,
	oiwf_item_if.sink        item,
	input  wire [7:0]        slave_addr,
	output oiwf_pkg::frame_t frame,
	output logic             frame_valid,
	input  wire              frame_ready
);
	import oiwf_pkg::*;

	logic   valid_s1;
	frame_t frame_s1;

	assign item.ready  = !valid_s1 || frame_ready;
	assign frame       = frame_s1;
	assign frame_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			frame_s1.addr    <= slave_addr;
			frame_s1.ctrl    <= item.func ? CTRL_DATA : CTRL_COMMAND;
			frame_s1.payload <= item.payload;
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !frame_ready) |=> (valid_s1 && $stable(frame_s1)))
		else $error("Stalled frame descriptor changed.");

	a_take_only_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> valid_s1)
		else $error("Accepted item was not registered.");

	a_ctrl_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (frame_s1.ctrl == CTRL_DATA || frame_s1.ctrl == CTRL_COMMAND))
		else $error("Control byte is neither command nor data.");

endmodule : oiwf_front
`default_nettype wire

// ===== rtl/oiwf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oiwf_queue
// Short FIFO of frame descriptors between the front and the sequencer.
// ----------------------------------------------------------------------------
module oiwf_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  oiwf_pkg::frame_t push_frame,
	input  wire              push_valid,
	output logic             push_ready,
	output oiwf_pkg::frame_t pop_frame,
	output logic             pop_valid,
	input  wire              pop_take
);
	import oiwf_pkg::*;

	frame_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_take && pop_valid;
	assign pop_frame  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_frame;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("Queue count out of range.");

	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_take && !pop_valid) |=> $stable(rptr_q))
		else $error("Read pointer moved on an empty queue.");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue count missed a push.");

endmodule : oiwf_queue
`default_nettype wire

// ===== rtl/oiwf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oiwf_back
// Symbol sequencer: walks one frame descriptor through its 29 bus symbols.
// ----------------------------------------------------------------------------
module oiwf_back (
	input  wire              clk,
	input  wire              arst_n,
	input  oiwf_pkg::frame_t frame,
	input  wire              frame_valid,
	output logic             frame_take,
	oiwf_symbol_if.source    symbol
);
	import oiwf_pkg::*;

	logic                  busy_q;
	logic [POS_W-1:0]      pos_q;
	logic [23:0]           shift_q;
	logic                  sym_valid_q;
	logic [SYM_KIND_W-1:0] kind_q;
	logic                  sda_q;
	logic                  last_q;
	logic                  adv;
	logic                  at_stop;
	logic [SYM_KIND_W-1:0] kind;

	assign adv        = !sym_valid_q || symbol.ready;
	assign at_stop    = busy_q && (pos_q == POS_STOP);
	assign frame_take = frame_valid && (!busy_q || (adv && at_stop));

	always_comb begin
		unique case (pos_q) inside
			POS_START: kind = SYM_START;
			POS_ACK0, POS_ACK1, POS_ACK2: kind = SYM_ACK;
			POS_STOP: kind = SYM_STOP;
			default: kind = SYM_BIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			sym_valid_q <= 1'b0;
		end else begin
			if (frame_take) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (adv && at_stop) begin
				busy_q <= 1'b0;
			end else if (adv && busy_q) begin
				pos_q <= pos_q + 1'b1;
			end
			if (adv) begin
				sym_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			shift_q <= {frame.addr, frame.ctrl, frame.payload};
		end else if (adv && busy_q && kind == SYM_BIT) begin
			shift_q <= {shift_q[22:0], 1'b0};
		end
		if (adv) begin
			kind_q <= kind;
			sda_q  <= (kind == SYM_BIT) ? shift_q[23] : 1'b0;
			last_q <= (kind == SYM_STOP);
		end
	end

	assign symbol.valid       = sym_valid_q;
	assign symbol.symbol_kind = kind_q;
	assign symbol.sda_level   = sda_q;
	assign symbol.last_symbol = last_q;

	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid_q && last_q) |-> (kind_q == SYM_STOP))
		else $error("Last symbol is not a stop.");

	a_sda_low_off_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid_q && kind_q != SYM_BIT) |-> !sda_q)
		else $error("Data line high outside a data bit.");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= POS_STOP))
		else $error("Symbol position past the stop.");

	a_start_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		frame_take |=> (busy_q && pos_q == POS_START))
		else $error("Loaded frame does not begin at start.");

endmodule : oiwf_back
`default_nettype wire

// ===== rtl/oled_i2c_write_framer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oled_i2c_write_framer_unit
// Expands a command or data byte into the write-only I2C frame of a display
// controller, one bus symbol per output transfer.
// ----------------------------------------------------------------------------
// Every input transfer yields 29 symbols: start, address byte, ack clock,
// control byte, ack clock, payload byte, ack clock, stop. The sequencer sends
// one symbol per cycle while the output is ready; the front register and a
// two-entry queue accept further items while a frame is still going out, and
// consecutive frames follow with no gap. From idle, an accepted item passes
// the front register, the queue and the sequencer position before the output
// register shows its first symbol. The address byte is sampled at acceptance.
module oled_i2c_write_framer_unit (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cfg_we,
	input  wire [7:0]     cfg_data,
	oiwf_item_if.sink     item,
	oiwf_symbol_if.source symbol
);
	import oiwf_pkg::*;

	logic [7:0] slave_addr_q;
	frame_t     front_frame;
	logic       front_valid;
	logic       front_ready;
	frame_t     queue_frame;
	logic       queue_valid;
	logic       queue_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RESET;
		end else if (cfg_we) begin
			slave_addr_q <= cfg_data;
		end
	end

	oiwf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.slave_addr  (slave_addr_q),
		.frame       (front_frame),
		.frame_valid (front_valid),
		.frame_ready (front_ready)
	);

	oiwf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_frame (front_frame),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_frame  (queue_frame),
		.pop_valid  (queue_valid),
		.pop_take   (queue_take)
	);

	oiwf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (queue_frame),
		.frame_valid (queue_valid),
		.frame_take  (queue_take),
		.symbol      (symbol)
	);

endmodule : oled_i2c_write_framer_unit
`default_nettype wire
